[rtl/cia_pkg.sv]
// Shared types and constants for the complex integer ALU.
`timescale 1ns / 1ps
package cia_pkg;

  localparam int unsigned ResWidth = 33;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_SCALE = 3'd4,
    MODE_INC   = 3'd5,
    MODE_EQ    = 3'd6
  } mode_e;

  typedef struct packed {
    logic                        valid;
    logic                        is_div;
    logic                        div_zero;
    logic                        is_equal;
    logic                        neg_r;
    logic                        neg_i;
    logic signed [ResWidth-1:0]  res_r;
    logic signed [ResWidth-1:0]  res_i;
  } side_t;

endpackage

[rtl/cia_front.sv]
// Front end: input register, product stage and combine stage.
`timescale 1ns / 1ps
module cia_front import cia_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [2:0]                        mode_i,
  input  logic signed [OPERAND_WIDTH-1:0]   a_real_i,
  input  logic signed [OPERAND_WIDTH-1:0]   a_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0]   b_real_i,
  input  logic signed [OPERAND_WIDTH-1:0]   b_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0]   scale_i,
  output side_t                             side_o,
  output logic [2*OPERAND_WIDTH-1:0]        num_r_o,
  output logic [2*OPERAND_WIDTH-1:0]        num_i_o,
  output logic [2*OPERAND_WIDTH-1:0]        den_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned NW = 2 * OPERAND_WIDTH;

  logic                v1_q;
  logic [2:0]          mode1_q;
  logic signed [W-1:0] ar1_q, ai1_q, br1_q, bi1_q, sc1_q;

  logic                 v2_q;
  logic [2:0]           mode2_q;
  logic signed [W-1:0]  ar2_q, ai2_q, br2_q, bi2_q;
  logic signed [NW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [W-1:0]  mr_op, mi_op;

  logic           v3_q;
  side_t          side_d, side_q;
  logic [NW-1:0]  num_r_d, num_r_q, num_i_d, num_i_q, den_d, den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= side_d.valid;
    end
  end

  assign mr_op = (mode1_q == MODE_SCALE) ? sc1_q : br1_q;
  assign mi_op = (mode1_q == MODE_SCALE) ? sc1_q : br1_q;

  always_ff @(posedge clk_i) begin
    mode1_q <= mode_i;
    ar1_q   <= a_real_i;
    ai1_q   <= a_imag_i;
    br1_q   <= b_real_i;
    bi1_q   <= b_imag_i;
    sc1_q   <= scale_i;

    mode2_q <= mode1_q;
    ar2_q   <= ar1_q;
    ai2_q   <= ai1_q;
    br2_q   <= br1_q;
    bi2_q   <= bi1_q;
    m0_q    <= NW'(ar1_q * mr_op);
    m1_q    <= NW'(ai1_q * bi1_q);
    m2_q    <= NW'(ai1_q * mi_op);
    m3_q    <= NW'(ar1_q * bi1_q);
    m4_q    <= NW'(br1_q * br1_q);
    m5_q    <= NW'(bi1_q * bi1_q);

    side_q  <= side_d;
    num_r_q <= num_r_d;
    num_i_q <= num_i_d;
    den_q   <= den_d;
  end

  always_comb begin
    logic signed [63:0] rr, ri, nr, ni, dd;
    rr = '0;
    ri = '0;
    nr = 64'(m0_q) + 64'(m1_q);
    ni = 64'(m2_q) - 64'(m3_q);
    dd = 64'(m4_q) + 64'(m5_q);
    side_d = '0;
    side_d.valid = v2_q;
    side_d.neg_r = nr < 0;
    side_d.neg_i = ni < 0;
    num_r_d = side_d.neg_r ? NW'(-nr) : NW'(nr);
    num_i_d = side_d.neg_i ? NW'(-ni) : NW'(ni);
    den_d   = NW'(dd);
    case (mode2_q)
      MODE_ADD: begin
        rr = 64'(ar2_q) + 64'(br2_q);
        ri = 64'(ai2_q) + 64'(bi2_q);
      end
      MODE_SUB: begin
        rr = 64'(ar2_q) - 64'(br2_q);
        ri = 64'(ai2_q) - 64'(bi2_q);
      end
      MODE_MUL: begin
        rr = 64'(m0_q) - 64'(m1_q);
        ri = 64'(m2_q) + 64'(m3_q);
      end
      MODE_DIV: begin
        if (dd == 0) side_d.div_zero = 1'b1;
        else side_d.is_div = 1'b1;
      end
      MODE_SCALE: begin
        rr = 64'(m0_q);
        ri = 64'(m2_q);
      end
      MODE_INC: begin
        rr = 64'(ar2_q) + 64'sd1;
        ri = 64'(ai2_q) + 64'sd1;
      end
      MODE_EQ: begin
        side_d.is_equal = (ar2_q == br2_q) && (ai2_q == bi2_q);
      end
      default: begin
        rr = '0;
        ri = '0;
      end
    endcase
    side_d.res_r = rr[ResWidth-1:0];
    side_d.res_i = ri[ResWidth-1:0];
  end

  always_comb begin
    side_o       = side_q;
    side_o.valid = v3_q;
  end

  assign num_r_o = num_r_q;
  assign num_i_o = num_i_q;
  assign den_o   = den_q;

endmodule

[rtl/cia_div_stage.sv]
// One restoring division step for both quotients, registered.
`timescale 1ns / 1ps
module cia_div_stage import cia_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16,
  parameter int unsigned STEP = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  side_t                          side_i,
  input  logic [2*OPERAND_WIDTH-1:0]     den_i,
  input  logic [2*OPERAND_WIDTH-1:0]     num_r_i,
  input  logic [2*OPERAND_WIDTH-1:0]     num_i_i,
  input  logic [2*OPERAND_WIDTH-1:0]     rem_r_i,
  input  logic [2*OPERAND_WIDTH-1:0]     rem_i_i,
  input  logic [OPERAND_WIDTH:0]         quo_r_i,
  input  logic [OPERAND_WIDTH:0]         quo_i_i,
  output side_t                          side_o,
  output logic [2*OPERAND_WIDTH-1:0]     den_o,
  output logic [2*OPERAND_WIDTH-1:0]     num_r_o,
  output logic [2*OPERAND_WIDTH-1:0]     num_i_o,
  output logic [2*OPERAND_WIDTH-1:0]     rem_r_o,
  output logic [2*OPERAND_WIDTH-1:0]     rem_i_o,
  output logic [OPERAND_WIDTH:0]         quo_r_o,
  output logic [OPERAND_WIDTH:0]         quo_i_o
);

  localparam int unsigned NW  = 2 * OPERAND_WIDTH;
  localparam int unsigned QW  = OPERAND_WIDTH + 1;
  localparam int unsigned BIT = QW - 1 - STEP;

  logic [NW:0]   t_r, t_i, dx;
  logic          ge_r, ge_i;
  logic          valid_q;
  side_t         side_q;
  logic [NW-1:0] den_q, num_r_q, num_i_q, rem_r_q, rem_i_q;
  logic [QW-1:0] quo_r_q, quo_i_q;

  assign dx   = {1'b0, den_i};
  assign t_r  = {rem_r_i, num_r_i[BIT]};
  assign t_i  = {rem_i_i, num_i_i[BIT]};
  assign ge_r = t_r >= dx;
  assign ge_i = t_i >= dx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q  <= side_i;
    den_q   <= den_i;
    num_r_q <= num_r_i;
    num_i_q <= num_i_i;
    rem_r_q <= ge_r ? NW'(t_r - dx) : NW'(t_r);
    rem_i_q <= ge_i ? NW'(t_i - dx) : NW'(t_i);
    quo_r_q <= {quo_r_i[QW-2:0], ge_r};
    quo_i_q <= {quo_i_i[QW-2:0], ge_i};
  end

  always_comb begin
    side_o       = side_q;
    side_o.valid = valid_q;
  end

  assign den_o   = den_q;
  assign num_r_o = num_r_q;
  assign num_i_o = num_i_q;
  assign rem_r_o = rem_r_q;
  assign rem_i_o = rem_i_q;
  assign quo_r_o = quo_r_q;
  assign quo_i_o = quo_i_q;

endmodule

[rtl/complex_integer_alu.sv]
// Top level of the complex integer ALU: front end, divider chain, output stage.
// One item is taken every cycle; busy_o is never raised. Every result passes
// through three front stages (input, products, combine), one restoring divider step per
// quotient bit (OPERAND_WIDTH + 1 stages) and the output register. All modes
// share the same latency, so results come out in item order.
`timescale 1ns / 1ps
module complex_integer_alu import cia_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [2:0]                       mode_i,
  input  logic signed [OPERAND_WIDTH-1:0]  a_real_i,
  input  logic signed [OPERAND_WIDTH-1:0]  a_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0]  b_real_i,
  input  logic signed [OPERAND_WIDTH-1:0]  b_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0]  scale_i,
  output logic                             valid_o,
  output logic signed [ResWidth-1:0]       res_real_o,
  output logic signed [ResWidth-1:0]       res_imag_o,
  output logic                             is_equal_o,
  output logic                             div_zero_o
);

  localparam int unsigned NW = 2 * OPERAND_WIDTH;
  localparam int unsigned QW = OPERAND_WIDTH + 1;

  side_t         side_s [QW+1];
  logic [NW-1:0] den_s  [QW+1];
  logic [NW-1:0] num_r_s[QW+1];
  logic [NW-1:0] num_i_s[QW+1];
  logic [NW-1:0] rem_r_s[QW+1];
  logic [NW-1:0] rem_i_s[QW+1];
  logic [QW-1:0] quo_r_s[QW+1];
  logic [QW-1:0] quo_i_s[QW+1];

  logic                        valid_q;
  logic signed [ResWidth-1:0]  res_r_q, res_i_q;
  logic                        eq_q, dz_q;

  assign busy_o = 1'b0;

  cia_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (mode_i),
    .a_real_i (a_real_i),
    .a_imag_i (a_imag_i),
    .b_real_i (b_real_i),
    .b_imag_i (b_imag_i),
    .scale_i  (scale_i),
    .side_o   (side_s[0]),
    .num_r_o  (num_r_s[0]),
    .num_i_o  (num_i_s[0]),
    .den_o    (den_s[0])
  );

  assign rem_r_s[0] = NW'(num_r_s[0] >> QW);
  assign rem_i_s[0] = NW'(num_i_s[0] >> QW);
  assign quo_r_s[0] = '0;
  assign quo_i_s[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    cia_div_stage #(.OPERAND_WIDTH(OPERAND_WIDTH), .STEP(k)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .side_i  (side_s[k]),
      .den_i   (den_s[k]),
      .num_r_i (num_r_s[k]),
      .num_i_i (num_i_s[k]),
      .rem_r_i (rem_r_s[k]),
      .rem_i_i (rem_i_s[k]),
      .quo_r_i (quo_r_s[k]),
      .quo_i_i (quo_i_s[k]),
      .side_o  (side_s[k+1]),
      .den_o   (den_s[k+1]),
      .num_r_o (num_r_s[k+1]),
      .num_i_o (num_i_s[k+1]),
      .rem_r_o (rem_r_s[k+1]),
      .rem_i_o (rem_i_s[k+1]),
      .quo_r_o (quo_r_s[k+1]),
      .quo_i_o (quo_i_s[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_s[QW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [63:0] qr, qi;
    qr = 64'(quo_r_s[QW]);
    qi = 64'(quo_i_s[QW]);
    if (side_s[QW].neg_r) qr = -qr;
    if (side_s[QW].neg_i) qi = -qi;
    if (side_s[QW].is_div) begin
      res_r_q <= qr[ResWidth-1:0];
      res_i_q <= qi[ResWidth-1:0];
    end else begin
      res_r_q <= side_s[QW].res_r;
      res_i_q <= side_s[QW].res_i;
    end
    eq_q <= side_s[QW].is_equal;
    dz_q <= side_s[QW].div_zero;
  end

  assign valid_o    = valid_q;
  assign res_real_o = res_r_q;
  assign res_imag_o = res_i_q;
  assign is_equal_o = eq_q;
  assign div_zero_o = dz_q;

endmodule

[rtl/cia_checker.sv]
// Port-level checks for the complex integer ALU, bound to the top level.
`timescale 1ns / 1ps
module cia_checker #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        valid_o,
  input logic [32:0] res_real_o,
  input logic [32:0] res_imag_o,
  input logic        is_equal_o,
  input logic        div_zero_o
);

  localparam int unsigned Lat = OPERAND_WIDTH + 5;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_strobe_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, Lat))
    else $error("result without item");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && div_zero_o) |-> (res_real_o == 33'd0 && res_imag_o == 33'd0 && !is_equal_o))
    else $error("divide by zero result not clear");

  a_eq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_equal_o) |-> (res_real_o == 33'd0 && res_imag_o == 33'd0))
    else $error("equal result not clear");

endmodule

bind complex_integer_alu cia_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_cia_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .valid_o    (valid_o),
  .res_real_o (res_real_o),
  .res_imag_o (res_imag_o),
  .is_equal_o (is_equal_o),
  .div_zero_o (div_zero_o)
);

[sim/cia_checker.sv]
// Checker for the complex integer ALU: predicts each result and compares it.
`timescale 1ns / 1ps
module cia_scoreboard import cia_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [2:0]                       mode_i,
  input  logic signed [OPERAND_WIDTH-1:0]  a_real_i,
  input  logic signed [OPERAND_WIDTH-1:0]  a_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0]  b_real_i,
  input  logic signed [OPERAND_WIDTH-1:0]  b_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0]  scale_i,
  input  logic                             valid_i,
  input  logic signed [ResWidth-1:0]       res_real_i,
  input  logic signed [ResWidth-1:0]       res_imag_i,
  input  logic                             is_equal_i,
  input  logic                             div_zero_i,
  output int                               errors_o,
  output int                               pending_o
);

  typedef struct packed {
    logic signed [ResWidth-1:0] re;
    logic signed [ResWidth-1:0] im;
    logic                       eq;
    logic                       dz;
  } cplx_res_t;

  cplx_res_t pending_q[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic cplx_res_t compute_result(logic [2:0] mode, longint ar, longint ai,
                                               longint br, longint bi, longint sc);
    cplx_res_t r;
    longint    rr, ri, den;
    rr = 0;
    ri = 0;
    r  = '0;
    case (mode)
      MODE_ADD: begin
        rr = ar + br; ri = ai + bi;
      end
      MODE_SUB: begin
        rr = ar - br; ri = ai - bi;
      end
      MODE_MUL: begin
        rr = ar * br - ai * bi; ri = ai * br + ar * bi;
      end
      MODE_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          rr = (ar * br + ai * bi) / den;
          ri = (ai * br - ar * bi) / den;
        end
      end
      MODE_SCALE: begin
        rr = ar * sc; ri = ai * sc;
      end
      MODE_INC: begin
        rr = ar + 1; ri = ai + 1;
      end
      MODE_EQ: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    r.re = rr[ResWidth-1:0];
    r.im = ri[ResWidth-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    cplx_res_t want;
    if (start_i && !busy_i)
      pending_q.push_back(compute_result(mode_i, a_real_i, a_imag_i, b_real_i, b_imag_i,
                                         scale_i));
    if (valid_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_q.pop_front();
        if (res_real_i !== want.re) report_mismatch("res_real", res_real_i, want.re);
        if (res_imag_i !== want.im) report_mismatch("res_imag", res_imag_i, want.im);
        if (is_equal_i !== want.eq) report_mismatch("is_equal", is_equal_i, want.eq);
        if (div_zero_i !== want.dz) report_mismatch("div_zero", div_zero_i, want.dz);
      end
    end
    pending_o = pending_q.size();
  end

endmodule

[sim/tb_complex_integer_alu.sv]
// Testbench top for the complex integer ALU: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_complex_integer_alu import cia_pkg::*;;

  localparam int unsigned W = 16;
  localparam int WatchdogLimit = 2000;

  logic                    clk, rst_n, start, busy, valid, is_eq, div_z;
  logic [2:0]              mode;
  logic signed [W-1:0]     ar, ai, br, bi, sc;
  logic signed [ResWidth-1:0] rr, ri;
  int                      errors, pending, idle_cycles;

  complex_integer_alu #(.OPERAND_WIDTH(W)) dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .mode_i(mode),
    .a_real_i(ar), .a_imag_i(ai), .b_real_i(br), .b_imag_i(bi), .scale_i(sc),
    .valid_o(valid), .res_real_o(rr), .res_imag_o(ri), .is_equal_o(is_eq),
    .div_zero_o(div_z)
  );

  cia_scoreboard #(.OPERAND_WIDTH(W)) checker_i (
    .clk_i(clk), .start_i(start), .busy_i(busy), .mode_i(mode), .a_real_i(ar),
    .a_imag_i(ai), .b_real_i(br), .b_imag_i(bi), .scale_i(sc), .valid_i(valid),
    .res_real_i(rr), .res_imag_i(ri), .is_equal_i(is_eq), .div_zero_i(div_z),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((start && !busy) || valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic signed [W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'(int'($urandom_range(0, 6)) - 3);
      4: return 16'(int'($urandom_range(0, 40)) - 20);
      default: return W'($urandom);
    endcase
  endfunction

  task automatic send_item(logic [2:0] m, logic signed [W-1:0] x_r, logic signed [W-1:0] x_i,
                           logic signed [W-1:0] y_r, logic signed [W-1:0] y_i,
                           logic signed [W-1:0] s);
    start <= 1'b1;
    mode <= m; ar <= x_r; ai <= x_i; br <= y_r; bi <= y_i; sc <= s;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic send_random(int n, int gap_pct);
    logic signed [W-1:0] x_r, x_i, y_r, y_i;
    for (int k = 0; k < n; k++) begin
      while ($urandom_range(0, 99) < gap_pct) begin
        start <= 1'b0;
        @(negedge clk);
      end
      x_r = pick_operand();
      x_i = pick_operand();
      y_r = pick_operand();
      y_i = pick_operand();
      if ($urandom_range(0, 3) == 0) begin
        y_r = x_r; y_i = x_i;
      end
      if ($urandom_range(0, 9) == 0) begin
        y_r = '0; y_i = '0;
      end
      send_item(3'($urandom_range(0, 7)), x_r, x_i, y_r, y_i, pick_operand());
    end
    start <= 1'b0;
  endtask

  initial begin
    logic signed [W-1:0] mx, mn;
    mx = 16'sh7fff;
    mn = 16'sh8000;
    rst_n = 1'b0; start = 1'b0; mode = MODE_ADD;
    ar = '0; ai = '0; br = '0; bi = '0; sc = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_item(MODE_ADD, mx, mn, mx, mn, 0);
    send_item(MODE_SUB, mx, mn, mn, mx, 0);
    send_item(MODE_MUL, mn, mn, mn, mn, 0);
    send_item(MODE_MUL, mx, mn, mn, mx, 0);
    send_item(MODE_DIV, mn, mn, 1, 0, 0);
    send_item(MODE_DIV, 7, -7, 2, 1, 0);
    send_item(MODE_DIV, -7, 7, -2, -1, 0);
    send_item(MODE_DIV, mx, mn, 0, 0, 0);
    send_item(MODE_DIV, 1, 1, mn, mn, 0);
    send_item(MODE_SCALE, mn, mx, 0, 0, mn);
    send_item(MODE_SCALE, mx, mn, 0, 0, mx);
    send_item(MODE_INC, mx, -1, 0, 0, 0);
    send_item(MODE_INC, mn, mx, 0, 0, 0);
    send_item(MODE_EQ, 5, -5, 5, -5, 0);
    send_item(MODE_EQ, 5, -5, 5, -4, 0);
    send_item(MODE_EQ, mn, mx, mn, mx, 0);
    send_item(3'd7, mx, mx, mx, mx, mx);
    start <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    send_random(270, 31);
    send_random(270, 51);
    send_random(270, 0);

    wait (pending == 0);
    repeat (W + 10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/cia_pkg.sv
rtl/cia_front.sv
rtl/cia_div_stage.sv
rtl/complex_integer_alu.sv
rtl/cia_checker.sv
sim/cia_checker.sv
sim/tb_complex_integer_alu.sv
